>>> design/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser - shared types and constants
// Transaction payloads, queue entry format and byte codes of the track parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam int TICK_W              = 32;
    localparam int MAX_DELTA_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH_DEF     = 4;
    localparam int SCALE_W             = 16;
    localparam int CFG_ADDR_W          = 3;
    localparam int CFG_DATA_W          = 32;

    // Configuration register indexes (byte address 4*index)
    localparam logic [0:0] REG_SCALE_ENABLE = 1'b0;
    localparam logic [0:0] REG_TICK_SCALE   = 1'b1;

    // Byte codes
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] META_STATUS = 8'hFF;
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;
    localparam logic [3:0] NIB_PRESSURE = 4'hD;
    localparam logic [3:0] NIB_SYSTEM   = 4'hF;

    // Error codes
    localparam logic ERR_STATUS = 1'b0;
    localparam logic ERR_DELTA  = 1'b1;

    typedef enum logic [1:0] {
        KIND_CHANNEL = 2'd0,
        KIND_SYSEX   = 2'd1,
        KIND_META    = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       track_start;
    } in_t;

    typedef struct packed {
        kind_t              kind;
        logic [3:0]         status_nibble;
        logic [3:0]         channel;
        logic [7:0]         first_data;
        logic [7:0]         second_data;
        logic [7:0]         meta_type;
        logic [7:0]         payload_byte;
        logic               payload_valid;
        logic               last_of_event;
        logic [TICK_W-1:0]  tick;
        logic               error_code;
    } out_t;

    // Front-to-back queue entry: optional new track time, optional result
    typedef struct packed {
        logic              upd_time;
        logic [TICK_W-1:0] track_time;
        logic              has_res;
        out_t              res;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> design/mtep_front.sv
// ----------------------------------------------------------------------------
// MIDI track event parser - front end
// Byte classifier: delta-time decode, saturating track time, event framing.
// ----------------------------------------------------------------------------
module mtep_front #(
    parameter int MAX_DELTA_BYTES = mtep_pkg::MAX_DELTA_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  mtep_pkg::in_t     in_data,
    output logic              push,
    output mtep_pkg::entry_t  push_entry
);

    localparam int ACC_W = 7 * MAX_DELTA_BYTES;
    localparam int CNT_W = $clog2(MAX_DELTA_BYTES + 1);
    localparam int SUM_W = ((ACC_W > mtep_pkg::TICK_W) ? ACC_W : mtep_pkg::TICK_W) + 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_DELTA_BYTES);

    typedef enum logic [3:0] {
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_SYSEX_EMPTY,
        PH_SYSEX_HELD, PH_META_TYPE, PH_META_LEN, PH_META_DATA, PH_HALT
    } phase_t;

    phase_t                      phase_reg, phase_next, cur_phase;
    logic [ACC_W-1:0]            accum_reg, accum_next, cur_accum;
    logic [CNT_W-1:0]            cnt_reg, cnt_next, cur_cnt, cnt_inc;
    logic [mtep_pkg::TICK_W-1:0] track_reg, track_next, cur_track;
    logic [7:0]                  status_reg, status_next;
    logic [7:0]                  held_reg, held_next;
    logic [7:0]                  mtype_reg, mtype_next;
    logic [ACC_W-1:0]            left_reg, left_next;
    logic [ACC_W+6:0]            accum_sh, left_sh;
    logic [SUM_W-1:0]            sum;
    logic [7:0]                  b;
    logic                        more;

    assign b = in_data.data_byte;
    assign more = b[7];

    always_comb begin
        // track start clears the parser before the byte is parsed
        cur_phase = in_data.track_start ? PH_DELTA : phase_reg;
        cur_accum = in_data.track_start ? '0 : accum_reg;
        cur_cnt   = in_data.track_start ? '0 : cnt_reg;
        cur_track = in_data.track_start ? '0 : track_reg;

        accum_sh = {cur_accum, b[6:0]};
        left_sh  = {left_reg, b[6:0]};
        cnt_inc  = cur_cnt + CNT_W'(1);
        sum      = SUM_W'(cur_track) + SUM_W'(accum_sh[ACC_W-1:0]);

        phase_next  = cur_phase;
        accum_next  = cur_accum;
        cnt_next    = cur_cnt;
        track_next  = cur_track;
        status_next = status_reg;
        held_next   = held_reg;
        mtype_next  = mtype_reg;
        left_next   = left_reg;

        push                  = in_data.track_start;
        push_entry            = '0;
        push_entry.upd_time   = in_data.track_start;
        push_entry.track_time = '0;

        unique case (cur_phase)
            PH_DELTA: begin
                if (more) begin
                    accum_next = accum_sh[ACC_W-1:0];
                    cnt_next   = cnt_inc;
                    if (cnt_inc >= CNT_LIMIT) begin
                        phase_next                = PH_HALT;
                        push                      = 1'b1;
                        push_entry.has_res        = 1'b1;
                        push_entry.res.kind       = mtep_pkg::KIND_ERROR;
                        push_entry.res.error_code = mtep_pkg::ERR_DELTA;
                    end
                end else begin
                    // saturate the absolute time at all ones
                    if (|(sum >> mtep_pkg::TICK_W)) begin
                        track_next = '1;
                    end else begin
                        track_next = sum[mtep_pkg::TICK_W-1:0];
                    end
                    accum_next            = '0;
                    cnt_next              = '0;
                    phase_next            = PH_STATUS;
                    push                  = 1'b1;
                    push_entry.upd_time   = 1'b1;
                    push_entry.track_time = track_next;
                end
            end
            PH_STATUS: begin
                if (!more) begin
                    phase_next                = PH_HALT;
                    push                      = 1'b1;
                    push_entry.has_res        = 1'b1;
                    push_entry.res.kind       = mtep_pkg::KIND_ERROR;
                    push_entry.res.error_code = mtep_pkg::ERR_STATUS;
                end else begin
                    status_next = b;
                    if (b[7:4] != mtep_pkg::NIB_SYSTEM) begin
                        phase_next = PH_DATA1;
                    end else if (b == mtep_pkg::SYSEX_START || b == mtep_pkg::SYSEX_END) begin
                        phase_next = PH_SYSEX_EMPTY;
                    end else if (b == mtep_pkg::META_STATUS) begin
                        phase_next = PH_META_TYPE;
                    end else begin
                        phase_next = PH_DELTA;
                    end
                end
            end
            PH_DATA1: begin
                held_next = b;
                if (status_reg[7:4] == mtep_pkg::NIB_PROGRAM ||
                    status_reg[7:4] == mtep_pkg::NIB_PRESSURE) begin
                    phase_next                   = PH_DELTA;
                    push                         = 1'b1;
                    push_entry.has_res           = 1'b1;
                    push_entry.res.kind          = mtep_pkg::KIND_CHANNEL;
                    push_entry.res.status_nibble = status_reg[7:4];
                    push_entry.res.channel       = status_reg[3:0];
                    push_entry.res.first_data    = b;
                end else begin
                    phase_next = PH_DATA2;
                end
            end
            PH_DATA2: begin
                phase_next                   = PH_DELTA;
                push                         = 1'b1;
                push_entry.has_res           = 1'b1;
                push_entry.res.kind          = mtep_pkg::KIND_CHANNEL;
                push_entry.res.status_nibble = status_reg[7:4];
                push_entry.res.channel       = status_reg[3:0];
                push_entry.res.first_data    = held_reg;
                push_entry.res.second_data   = b;
            end
            PH_SYSEX_EMPTY: begin
                if (b == mtep_pkg::SYSEX_END) begin
                    phase_next                   = PH_DELTA;
                    push                         = 1'b1;
                    push_entry.has_res           = 1'b1;
                    push_entry.res.kind          = mtep_pkg::KIND_SYSEX;
                    push_entry.res.last_of_event = 1'b1;
                end else begin
                    held_next  = b;
                    phase_next = PH_SYSEX_HELD;
                end
            end
            PH_SYSEX_HELD: begin
                // hold each byte until the next one arrives so the end marker can flag it last
                push                         = 1'b1;
                push_entry.has_res           = 1'b1;
                push_entry.res.kind          = mtep_pkg::KIND_SYSEX;
                push_entry.res.payload_byte  = held_reg;
                push_entry.res.payload_valid = 1'b1;
                if (b == mtep_pkg::SYSEX_END) begin
                    phase_next                   = PH_DELTA;
                    push_entry.res.last_of_event = 1'b1;
                end else begin
                    held_next = b;
                end
            end
            PH_META_TYPE: begin
                mtype_next = b;
                left_next  = '0;
                cnt_next   = '0;
                phase_next = PH_META_LEN;
            end
            PH_META_LEN: begin
                left_next = left_sh[ACC_W-1:0];
                if (more) begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= CNT_LIMIT) begin
                        phase_next                = PH_HALT;
                        push                      = 1'b1;
                        push_entry.has_res        = 1'b1;
                        push_entry.res.kind       = mtep_pkg::KIND_ERROR;
                        push_entry.res.error_code = mtep_pkg::ERR_DELTA;
                    end
                end else begin
                    cnt_next = '0;
                    if (left_sh[ACC_W-1:0] == '0) begin
                        phase_next                   = PH_DELTA;
                        push                         = 1'b1;
                        push_entry.has_res           = 1'b1;
                        push_entry.res.kind          = mtep_pkg::KIND_META;
                        push_entry.res.meta_type     = mtype_reg;
                        push_entry.res.last_of_event = 1'b1;
                    end else begin
                        phase_next = PH_META_DATA;
                    end
                end
            end
            PH_META_DATA: begin
                left_next                    = left_reg - ACC_W'(1);
                push                         = 1'b1;
                push_entry.has_res           = 1'b1;
                push_entry.res.kind          = mtep_pkg::KIND_META;
                push_entry.res.meta_type     = mtype_reg;
                push_entry.res.payload_byte  = b;
                push_entry.res.payload_valid = 1'b1;
                if (left_reg == ACC_W'(1)) begin
                    phase_next                   = PH_DELTA;
                    push_entry.res.last_of_event = 1'b1;
                end
            end
            PH_HALT: begin
                phase_next = PH_HALT;
            end
            default: begin
                phase_next = PH_HALT;
            end
        endcase

        if (!in_fire) begin
            push = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DELTA;
            accum_reg <= '0;
            cnt_reg   <= '0;
            track_reg <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            cnt_reg   <= cnt_next;
            track_reg <= track_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            status_reg <= status_next;
            held_reg   <= held_next;
            mtype_reg  <= mtype_next;
            left_reg   <= left_next;
        end
    end

endmodule

>>> design/mtep_queue.sv
// ----------------------------------------------------------------------------
// MIDI track event parser - decoupling queue
// Small register FIFO between the byte classifier and the result stage.
// ----------------------------------------------------------------------------
module mtep_queue #(
    parameter int QUEUE_DEPTH = mtep_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  mtep_pkg::entry_t        push_entry,
    input  logic                    pop,
    output mtep_pkg::entry_t        head,
    output mtep_pkg::queue_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    mtep_pkg::entry_t q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head         = q_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> design/mtep_back.sv
// ----------------------------------------------------------------------------
// MIDI track event parser - back end
// Tick scaling with saturation and the registered result stage.
// ----------------------------------------------------------------------------
module mtep_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          scale_enable,
    input  logic [mtep_pkg::SCALE_W-1:0]  tick_scale,
    input  mtep_pkg::entry_t              head,
    input  mtep_pkg::queue_status_t       q_status,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mtep_pkg::out_t                m_data
);

    localparam int PROD_W = mtep_pkg::TICK_W + mtep_pkg::SCALE_W;

    logic [PROD_W-1:0]           prod;
    logic [mtep_pkg::TICK_W-1:0] scaled;
    logic [mtep_pkg::TICK_W-1:0] event_time_reg;
    logic                        m_valid_reg;
    mtep_pkg::out_t              m_data_reg, res_next;

    assign prod = PROD_W'(head.track_time) * PROD_W'(tick_scale);

    always_comb begin
        if (!scale_enable) begin
            scaled = head.track_time;
        end else if (|prod[PROD_W-1:mtep_pkg::TICK_W]) begin
            scaled = '1;
        end else begin
            scaled = prod[mtep_pkg::TICK_W-1:0];
        end
        res_next      = head.res;
        res_next.tick = head.upd_time ? scaled : event_time_reg;
    end

    assign pop     = !q_status.empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            event_time_reg <= '0;
        end else begin
            // a pop only happens when the result register is free or leaving
            if (pop) begin
                m_valid_reg <= head.has_res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop && head.upd_time) begin
                event_time_reg <= scaled;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head.has_res) begin
            m_data_reg <= res_next;
        end
    end

endmodule

>>> design/midi_track_event_parser_top.sv
// ----------------------------------------------------------------------------
// MIDI track event parser - top level
// Parses track chunk bytes into channel events, sysex and meta bytes, errors.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  s_       | in        | s_valid / s_ready    | mtep_pkg::in_t  (one track byte)
//  m_       | out       | m_valid / m_ready    | mtep_pkg::out_t (one result)
//  APB      | in        | psel/penable/pready  | scale_enable @0x0, tick_scale @0x4
//
//  One byte is accepted per cycle while the queue has room. A byte that
//  yields a result pushes it into the queue at the accepting edge, and the
//  result register takes it once free or emptying, which raises m_valid.
//  Front and result stage each move one queue entry a cycle, so the
//  sustained rate is one byte per cycle while m_ready stays high.
//  Reset (aresetn low, synchronous) clears parser, queue, m_valid, event
//  time and scale_enable and sets tick_scale to 1. A stalled m_ready fills
//  the queue; s_ready is low until a pop, and rises in the cycle after it.
// ----------------------------------------------------------------------------
module midi_track_event_parser_top #(
    parameter int MAX_DELTA_BYTES = mtep_pkg::MAX_DELTA_BYTES_DEF,
    parameter int QUEUE_DEPTH     = mtep_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input transactions
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mtep_pkg::in_t                      s_data,
    // result transactions
    output logic                               m_valid,
    input  logic                               m_ready,
    output mtep_pkg::out_t                     m_data,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mtep_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [mtep_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [mtep_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic                           scale_enable_reg;
    logic [mtep_pkg::SCALE_W-1:0]   tick_scale_reg;
    logic                           cfg_write;
    logic [0:0]                     cfg_index;

    logic                           in_fire;
    logic                           push;
    logic                           pop;
    mtep_pkg::entry_t               push_entry;
    mtep_pkg::entry_t               head;
    mtep_pkg::queue_status_t        q_status;

    // Configuration port: pready tied high, word registers at 4*index
    assign pready    = 1'b1;
    assign cfg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            mtep_pkg::REG_SCALE_ENABLE: prdata = mtep_pkg::CFG_DATA_W'(scale_enable_reg);
            mtep_pkg::REG_TICK_SCALE:   prdata = mtep_pkg::CFG_DATA_W'(tick_scale_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_enable_reg <= 1'b0;
            tick_scale_reg   <= mtep_pkg::SCALE_W'(1);
        end else if (cfg_write) begin
            unique case (cfg_index)
                mtep_pkg::REG_SCALE_ENABLE: scale_enable_reg <= pwdata[0];
                mtep_pkg::REG_TICK_SCALE:   tick_scale_reg <= pwdata[mtep_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept a byte whenever the queue has room; each byte pushes at most
    // one entry, so room for one entry is all the front needs.
    assign s_ready = !q_status.full;
    assign in_fire = s_valid && s_ready;

    mtep_front #(
        .MAX_DELTA_BYTES (MAX_DELTA_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_data    (s_data),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple the classifier from the output stall
    mtep_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Scale times and drive the result register
    mtep_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .scale_enable (scale_enable_reg),
        .tick_scale   (tick_scale_reg),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule
